// ===== hw/rtl/fmrpc_pkg.sv =====
// ----------------------------------------------------------------------------
// fmrpc_pkg
// Types, constants and codes shared by the packet classifier modules.
// ----------------------------------------------------------------------------
package fmrpc_pkg;

  localparam int unsigned RULE_DEPTH_DEF = 4096;
  localparam int unsigned CFG_DATA_W     = 13;
  localparam int unsigned CFG_IDX_W      = 2;

  localparam logic [31:0] NO_RULE_PRIO = 32'hFFFF_FFFF;
  localparam logic [5:0]  PREFIX_MAX   = 6'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_BANK    = 2'd0,
    CFG_DEFAULT_ACTION = 2'd1,
    CFG_RULES_IN_USE   = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    REQ_CLASSIFY = 1'b0,
    REQ_WRITE    = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT
  } scan_state_t;

  // One stored rule: addresses and port ranges, then priority, protocol,
  // saturated prefix lengths and action.
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] src_ports;
    logic [31:0] dst_ports;
    logic [31:0] priority_tag;
    logic [7:0]  proto;
    logic [5:0]  src_len;
    logic [5:0]  dst_len;
    logic        action;
  } rule_t;

  // Packet header fields that a classify request carries.
  typedef struct packed {
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
  } pkt_t;

  // Configuration register contents.
  typedef struct packed {
    logic        active_bank;
    logic        miss_action;
    logic [12:0] rules_in_use;
  } cfg_t;

endpackage

// ===== hw/rtl/fmrpc_ifs.sv =====
// ----------------------------------------------------------------------------
// fmrpc channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface fmrpc_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic        bank;
  logic [11:0] rule_index;
  logic [7:0]  proto;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [5:0]  src_prefix_len;
  logic [5:0]  dst_prefix_len;
  logic [31:0] src_ports;
  logic [31:0] dst_ports;
  logic [31:0] rule_priority;
  logic        rule_action;

  modport source (
    output valid, req_type, bank, rule_index, proto, src_addr, dst_addr,
           src_prefix_len, dst_prefix_len, src_ports, dst_ports,
           rule_priority, rule_action,
    input  ready
  );
  modport sink (
    input  valid, req_type, bank, rule_index, proto, src_addr, dst_addr,
           src_prefix_len, dst_prefix_len, src_ports, dst_ports,
           rule_priority, rule_action,
    output ready
  );
endinterface

interface fmrpc_res_if;
  logic        valid;
  logic        ready;
  logic        verdict;
  logic [31:0] matched_priority;
  logic        rule_hit;

  modport source (output valid, verdict, matched_priority, rule_hit, input ready);
  modport sink   (input valid, verdict, matched_priority, rule_hit, output ready);
endinterface

interface fmrpc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [fmrpc_pkg::CFG_IDX_W-1:0]   index;
  logic [fmrpc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/fmrpc_rule_mem.sv =====
// ----------------------------------------------------------------------------
// fmrpc_rule_mem
// Rule storage for both banks: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fmrpc_rule_mem #(
  parameter int unsigned ADDR_W = 13
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  fmrpc_pkg::rule_t    wdata,
  input  logic                re,
  input  logic [ADDR_W-1:0]   raddr,
  output fmrpc_pkg::rule_t    rdata
);

  fmrpc_pkg::rule_t mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/fmrpc_match.sv =====
// ----------------------------------------------------------------------------
// fmrpc_match
// Compares one rule against the packet header: protocol, prefixes, ports.
// ----------------------------------------------------------------------------
module fmrpc_match (
  input  fmrpc_pkg::rule_t rule,
  input  fmrpc_pkg::pkt_t  pkt,
  output logic             hit
);

  logic [31:0] src_mask;
  logic [31:0] dst_mask;
  logic        proto_ok;
  logic        src_ok;
  logic        dst_ok;
  logic        sport_ok;
  logic        dport_ok;

  // A prefix length of zero shifts the mask fully out, which matches any address.
  always_comb begin
    src_mask = 32'hFFFF_FFFF << (fmrpc_pkg::PREFIX_MAX - rule.src_len);
    dst_mask = 32'hFFFF_FFFF << (fmrpc_pkg::PREFIX_MAX - rule.dst_len);
    proto_ok = (rule.proto == 8'd0) || (rule.proto == pkt.proto);
    src_ok   = ((pkt.src_addr ^ rule.src_addr) & src_mask) == 32'd0;
    dst_ok   = ((pkt.dst_addr ^ rule.dst_addr) & dst_mask) == 32'd0;
    sport_ok = (rule.src_ports == 32'd0) ||
               ((pkt.sport >= rule.src_ports[15:0]) &&
                (pkt.sport <= rule.src_ports[31:16]));
    dport_ok = (rule.dst_ports == 32'd0) ||
               ((pkt.dport >= rule.dst_ports[15:0]) &&
                (pkt.dport <= rule.dst_ports[31:16]));
    hit      = proto_ok && src_ok && dst_ok && sport_ok && dport_ok;
  end

endmodule

// ===== hw/rtl/fmrpc_scan_ctrl.sv =====
// ----------------------------------------------------------------------------
// fmrpc_scan_ctrl
// Request sequencer: stores rules and scans the active bank one rule a cycle.
// ----------------------------------------------------------------------------
module fmrpc_scan_ctrl #(
  parameter int unsigned RULE_DEPTH = fmrpc_pkg::RULE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fmrpc_pkg::cfg_t      cfg_regs,
  fmrpc_req_if.sink            req,
  fmrpc_res_if.source          res
);

  localparam int unsigned SLOT_W = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
  localparam int unsigned ADDR_W = SLOT_W + 1;
  localparam int unsigned CNT_W  = $clog2(RULE_DEPTH + 1);

  fmrpc_pkg::scan_state_t state, state_next;

  logic [CNT_W-1:0]   issue_idx;
  logic [CNT_W-1:0]   limit;
  logic               rd_valid;
  logic               scan_bank;
  logic               dflt_action;
  fmrpc_pkg::pkt_t    pkt;

  logic               pend_verdict;
  logic [31:0]        pend_prio;
  logic               pend_hit;

  logic               out_valid;
  logic               out_verdict;
  logic [31:0]        out_prio;
  logic               out_hit;

  logic               accept;
  logic               idx_ok;
  logic               issue;
  logic               hit;
  logic               hit_now;
  logic               exhausted;
  logic               load_out;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ADDR_W-1:0]  mem_raddr;
  fmrpc_pkg::rule_t   mem_wdata;
  fmrpc_pkg::rule_t   mem_rdata;
  logic [31:0]        lim_wide;

  fmrpc_rule_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (issue),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fmrpc_match u_match (
    .rule (mem_rdata),
    .pkt  (pkt),
    .hit  (hit)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      fmrpc_pkg::ST_IDLE: begin
        if (accept && (req.req_type == fmrpc_pkg::REQ_CLASSIFY)) begin
          state_next = fmrpc_pkg::ST_SCAN;
        end
      end
      fmrpc_pkg::ST_SCAN: begin
        if (hit_now || exhausted) begin
          state_next = fmrpc_pkg::ST_WAIT;
        end
      end
      fmrpc_pkg::ST_WAIT: begin
        if (load_out) begin
          state_next = fmrpc_pkg::ST_IDLE;
        end
      end
      default: state_next = fmrpc_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    req.ready = (state == fmrpc_pkg::ST_IDLE);
    accept    = req.valid && req.ready;
    idx_ok    = {20'd0, req.rule_index} < 32'(RULE_DEPTH);
    mem_we    = accept && (req.req_type == fmrpc_pkg::REQ_WRITE) && idx_ok;
    mem_waddr = {req.bank, SLOT_W'(req.rule_index)};

    mem_wdata.src_addr     = req.src_addr;
    mem_wdata.dst_addr     = req.dst_addr;
    mem_wdata.src_ports    = req.src_ports;
    mem_wdata.dst_ports    = req.dst_ports;
    mem_wdata.priority_tag = req.rule_priority;
    mem_wdata.proto        = req.proto;
    mem_wdata.src_len      = (req.src_prefix_len > fmrpc_pkg::PREFIX_MAX) ?
                             fmrpc_pkg::PREFIX_MAX : req.src_prefix_len;
    mem_wdata.dst_len      = (req.dst_prefix_len > fmrpc_pkg::PREFIX_MAX) ?
                             fmrpc_pkg::PREFIX_MAX : req.dst_prefix_len;
    mem_wdata.action       = req.rule_action;

    lim_wide  = ({19'd0, cfg_regs.rules_in_use} > 32'(RULE_DEPTH)) ?
                32'(RULE_DEPTH) : {19'd0, cfg_regs.rules_in_use};

    hit_now   = (state == fmrpc_pkg::ST_SCAN) && rd_valid && hit;
    // A read stays in flight until its compare is done, so the scan ends only
    // once every slot below the limit has been checked.
    exhausted = (state == fmrpc_pkg::ST_SCAN) && !rd_valid && (issue_idx == limit);
    issue     = (state == fmrpc_pkg::ST_SCAN) && (issue_idx < limit) && !hit_now;
    mem_raddr = {scan_bank, issue_idx[SLOT_W-1:0]};

    load_out  = (state == fmrpc_pkg::ST_WAIT) && (!out_valid || res.ready);

    res.valid            = out_valid;
    res.verdict          = out_verdict;
    res.matched_priority = out_prio;
    res.rule_hit         = out_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fmrpc_pkg::ST_IDLE;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
      issue_idx <= '0;
      limit     <= '0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      if (accept && (req.req_type == fmrpc_pkg::REQ_CLASSIFY)) begin
        issue_idx <= '0;
        limit     <= CNT_W'(lim_wide);
      end else if (issue) begin
        issue_idx <= issue_idx + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (req.req_type == fmrpc_pkg::REQ_CLASSIFY)) begin
      pkt.proto    <= req.proto;
      pkt.src_addr <= req.src_addr;
      pkt.dst_addr <= req.dst_addr;
      pkt.sport    <= req.src_ports[15:0];
      pkt.dport    <= req.dst_ports[15:0];
      scan_bank    <= cfg_regs.active_bank;
      dflt_action  <= cfg_regs.miss_action;
    end
    if (hit_now) begin
      pend_verdict <= mem_rdata.action;
      pend_prio    <= mem_rdata.priority_tag;
      pend_hit     <= 1'b1;
    end else if (exhausted) begin
      pend_verdict <= dflt_action;
      pend_prio    <= fmrpc_pkg::NO_RULE_PRIO;
      pend_hit     <= 1'b0;
    end
    if (load_out) begin
      out_verdict <= pend_verdict;
      out_prio    <= pend_prio;
      out_hit     <= pend_hit;
    end
  end

  // Compare data is only ever taken from a read issued while scanning.
  a_rd_from_scan: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> $past(state) == fmrpc_pkg::ST_SCAN)
    else $error("rule read data valid without a scan read");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (state == fmrpc_pkg::ST_SCAN) |-> (issue_idx <= limit))
    else $error("scan index ran past the rule limit");

  a_hit_reported: assert property (@(posedge clk) disable iff (rst)
    hit_now |=> (state == fmrpc_pkg::ST_WAIT) && pend_hit)
    else $error("matching rule not captured as a hit");

  a_result_from_wait: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == fmrpc_pkg::ST_WAIT)
    else $error("result presented without a finished scan");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state != fmrpc_pkg::ST_IDLE) |-> !mem_we)
    else $error("rule store written during a scan");

endmodule

// ===== hw/rtl/first_match_rule_packet_classifier.sv =====
// ----------------------------------------------------------------------------
// first_match_rule_packet_classifier: two-bank first-match five-tuple filter.
// A rule write is stored at the edge that accepts it. A classify beat ends in a
// result once rule k matches, or once none of the N scanned rules do; the scan
// reads one rule per cycle from the rule store. The next request is taken in the
// cycle in which the result appears, unless an earlier result is still unread.
// Reset clears config and control state; rule contents stay undefined.
// ----------------------------------------------------------------------------
module first_match_rule_packet_classifier #(
  parameter int unsigned RULE_DEPTH = fmrpc_pkg::RULE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  fmrpc_cfg_if.sink    cfg,
  fmrpc_req_if.sink    req,
  fmrpc_res_if.source  res
);

  fmrpc_pkg::cfg_t cfg_regs;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        fmrpc_pkg::CFG_ACTIVE_BANK:    cfg_regs.active_bank  <= cfg.data[0];
        fmrpc_pkg::CFG_DEFAULT_ACTION: cfg_regs.miss_action  <= cfg.data[0];
        fmrpc_pkg::CFG_RULES_IN_USE:   cfg_regs.rules_in_use <= cfg.data;
        default: ;
      endcase
    end
  end

  fmrpc_scan_ctrl #(
    .RULE_DEPTH (RULE_DEPTH)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .req      (req),
    .res      (res)
  );

endmodule

// ===== dv/tb_first_match_rule_packet_classifier.sv =====
// ----------------------------------------------------------------------------
// tb_first_match_rule_packet_classifier
// Drives rule writes and packet classify beats into the two-bank classifier.
// A scoreboard keeps its own copy of both rule banks and the configuration,
// predicts each verdict by a first-match scan and compares every result beat.
// ----------------------------------------------------------------------------
module tb_first_match_rule_packet_classifier;

  localparam int unsigned DEPTH          = fmrpc_pkg::RULE_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT    = 50_000;
  localparam int unsigned WRITE_SETTLE   = 4;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned PHASE_ITEMS    = 29;
  localparam int unsigned SMALL_SCAN     = 24;
  localparam int unsigned FILL_RULES     = 24;
  localparam logic [31:0] CATCH_ALL_PRIO = 32'd9000;

  typedef struct {
    fmrpc_pkg::req_kind_t kind;
    logic        bank;
    logic [11:0] rule_index;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [5:0]  src_len;
    logic [5:0]  dst_len;
    logic [31:0] src_ports;
    logic [31:0] dst_ports;
    logic [31:0] prio;
    logic        action;
  } req_beat_t;

  typedef struct packed {
    logic        verdict;
    logic [31:0] prio;
    logic        hit;
  } verdict_t;

  // Mirrors both rule banks and the registers, and holds the verdicts still owed.
  class verdict_scoreboard;
    fmrpc_pkg::rule_t rules[2][DEPTH];
    bit          written[2][DEPTH];
    logic        bank_sel;
    logic        default_verdict;
    logic [12:0] scan_limit;
    verdict_t    expected_q[$];
    int unsigned errors;
    int unsigned writes;
    int unsigned classifies;
    int unsigned hits;

    function new();
      bank_sel = 1'b0;
      default_verdict = 1'b0;
      scan_limit = '0;
      errors = 0;
      writes = 0;
      classifies = 0;
      hits = 0;
    endfunction

    static function logic [31:0] prefix_mask(logic [5:0] len);
      if (len == 6'd0) return 32'h0;
      return 32'hFFFF_FFFF << (32 - len);
    endfunction

    static function bit port_in_range(logic [15:0] port, logic [31:0] range);
      if (range == 32'h0) return 1'b1;
      return (port >= range[15:0]) && (port <= range[31:16]);
    endfunction

    function void set_reg(fmrpc_pkg::cfg_reg_t r, logic [12:0] v);
      case (r)
        fmrpc_pkg::CFG_ACTIVE_BANK:    bank_sel = v[0];
        fmrpc_pkg::CFG_DEFAULT_ACTION: default_verdict = v[0];
        fmrpc_pkg::CFG_RULES_IN_USE:   scan_limit = v;
        default: ;
      endcase
    endfunction

    function int unsigned scan_count();
      return (scan_limit > DEPTH) ? DEPTH : 32'(scan_limit);
    endfunction

    // Number of slots from slot 0 upward that hold a written rule.
    function int unsigned written_prefix(logic b);
      int unsigned n;
      n = 0;
      while (n < DEPTH && written[b][n]) n++;
      return n;
    endfunction

    function bit rule_fits(fmrpc_pkg::rule_t r, req_beat_t p);
      if (r.proto != 8'd0 && r.proto != p.proto) return 1'b0;
      if (((p.src_addr ^ r.src_addr) & prefix_mask(r.src_len)) != 32'h0) return 1'b0;
      if (((p.dst_addr ^ r.dst_addr) & prefix_mask(r.dst_len)) != 32'h0) return 1'b0;
      if (!port_in_range(p.src_ports[15:0], r.src_ports)) return 1'b0;
      return port_in_range(p.dst_ports[15:0], r.dst_ports);
    endfunction

    function void note_request(req_beat_t b);
      fmrpc_pkg::rule_t r;
      verdict_t    e;
      int unsigned n;
      if (b.kind == fmrpc_pkg::REQ_WRITE) begin
        if (b.rule_index >= DEPTH) return;
        r.src_addr     = b.src_addr;
        r.dst_addr     = b.dst_addr;
        r.src_ports    = b.src_ports;
        r.dst_ports    = b.dst_ports;
        r.priority_tag = b.prio;
        r.proto        = b.proto;
        r.src_len      = (b.src_len > fmrpc_pkg::PREFIX_MAX) ? fmrpc_pkg::PREFIX_MAX
                                                             : b.src_len;
        r.dst_len      = (b.dst_len > fmrpc_pkg::PREFIX_MAX) ? fmrpc_pkg::PREFIX_MAX
                                                             : b.dst_len;
        r.action       = b.action;
        rules[b.bank][b.rule_index] = r;
        written[b.bank][b.rule_index] = 1'b1;
        writes++;
        return;
      end
      classifies++;
      e = verdict_t'{default_verdict, fmrpc_pkg::NO_RULE_PRIO, 1'b0};
      n = scan_count();
      for (int unsigned i = 0; i < n; i++) begin
        if (rule_fits(rules[bank_sel][i], b)) begin
          e = verdict_t'{rules[bank_sel][i].action, rules[bank_sel][i].priority_tag, 1'b1};
          hits++;
          break;
        end
      end
      expected_q.push_back(e);
    endfunction

    function void check_result(verdict_t got);
      verdict_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: verdict %0d priority %h hit %0d",
                 $time, got.verdict, got.prio, got.hit);
        return;
      end
      want = expected_q.pop_front();
      if (got.verdict !== want.verdict) begin
        errors++;
        $display("%0t: verdict mismatch: expected %0d actual %0d",
                 $time, want.verdict, got.verdict);
      end
      if (got.prio !== want.prio) begin
        errors++;
        $display("%0t: matched_priority mismatch: expected %h actual %h",
                 $time, want.prio, got.prio);
      end
      if (got.hit !== want.hit) begin
        errors++;
        $display("%0t: rule_hit mismatch: expected %0d actual %0d",
                 $time, want.hit, got.hit);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int unsigned send_idle_pct = 17;
  int unsigned recv_stall_pct = 45;
  verdict_scoreboard sb = new();

  always #5 clk = ~clk;

  fmrpc_cfg_if cfg_ch ();
  fmrpc_req_if req_ch ();
  fmrpc_res_if res_ch ();

  first_match_rule_packet_classifier #(.RULE_DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .res (res_ch)
  );

  // Sampling in the active region of the rising edge sees the values of the handshake.
  always @(posedge clk) begin
    req_beat_t seen;
    if (!rst && req_ch.valid && req_ch.ready) begin
      seen.kind       = fmrpc_pkg::req_kind_t'(req_ch.req_type);
      seen.bank       = req_ch.bank;
      seen.rule_index = req_ch.rule_index;
      seen.proto      = req_ch.proto;
      seen.src_addr   = req_ch.src_addr;
      seen.dst_addr   = req_ch.dst_addr;
      seen.src_len    = req_ch.src_prefix_len;
      seen.dst_len    = req_ch.dst_prefix_len;
      seen.src_ports  = req_ch.src_ports;
      seen.dst_ports  = req_ch.dst_ports;
      seen.prio       = req_ch.rule_priority;
      seen.action     = req_ch.rule_action;
      sb.note_request(seen);
    end
    if (!rst && cfg_ch.valid && cfg_ch.ready) begin
      sb.set_reg(fmrpc_pkg::cfg_reg_t'(cfg_ch.index), cfg_ch.data);
    end
    if (!rst && res_ch.valid && res_ch.ready) begin
      sb.check_result(verdict_t'{res_ch.verdict, res_ch.matched_priority, res_ch.rule_hit});
    end
  end

  always @(negedge clk) begin
    res_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  function automatic logic [31:0] random_port_range();
    logic [15:0]  lo;
    logic [15:0]  hi;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return 32'h0;
    lo = 16'($urandom);
    hi = 16'($urandom);
    if (pick < 80 && lo > hi) return {lo, hi};
    return {hi, lo};
  endfunction

  function automatic logic [15:0] port_for_range(logic [31:0] range, logic [15:0] fallback);
    if (range == 32'h0 || range[15:0] > range[31:16]) return fallback;
    return 16'($urandom_range(range[31:16], range[15:0]));
  endfunction

  function automatic req_beat_t random_packet();
    req_beat_t p;
    p.kind       = fmrpc_pkg::REQ_CLASSIFY;
    p.bank       = 1'($urandom);
    p.rule_index = 12'($urandom);
    p.proto      = 8'($urandom);
    p.src_addr   = $urandom;
    p.dst_addr   = $urandom;
    p.src_len    = 6'($urandom);
    p.dst_len    = 6'($urandom);
    p.src_ports  = $urandom;
    p.dst_ports  = $urandom;
    p.prio       = $urandom;
    p.action     = 1'($urandom);
    return p;
  endfunction

  function automatic req_beat_t random_rule(logic b, logic [11:0] idx);
    req_beat_t p;
    p = random_packet();
    p.kind       = fmrpc_pkg::REQ_WRITE;
    p.bank       = b;
    p.rule_index = idx;
    if ($urandom_range(0, 99) < 30) p.proto = 8'd0;
    p.src_len   = 6'($urandom_range(0, 63));
    p.dst_len   = 6'($urandom_range(0, 63));
    p.src_ports = random_port_range();
    p.dst_ports = random_port_range();
    return p;
  endfunction

  // Builds a packet that should satisfy the rule in the given slot, unless the
  // rule carries an empty port range.
  function automatic req_beat_t packet_for_slot(logic b, int unsigned slot);
    req_beat_t   p;
    fmrpc_pkg::rule_t r;
    logic [31:0] m;
    p = random_packet();
    r = sb.rules[b][slot];
    if (r.proto != 8'd0) p.proto = r.proto;
    m = verdict_scoreboard::prefix_mask(r.src_len);
    p.src_addr = (p.src_addr & ~m) | (r.src_addr & m);
    m = verdict_scoreboard::prefix_mask(r.dst_len);
    p.dst_addr = (p.dst_addr & ~m) | (r.dst_addr & m);
    p.src_ports[15:0] = port_for_range(r.src_ports, p.src_ports[15:0]);
    p.dst_ports[15:0] = port_for_range(r.dst_ports, p.dst_ports[15:0]);
    return p;
  endfunction

  function automatic req_beat_t mk_rule(logic b, int unsigned idx, logic [7:0] proto,
                                        logic [31:0] sa, logic [5:0] sl, logic [31:0] da,
                                        logic [5:0] dl, logic [31:0] sp, logic [31:0] dp,
                                        logic [31:0] prio, logic act);
    req_beat_t p;
    p.kind       = fmrpc_pkg::REQ_WRITE;
    p.bank       = b;
    p.rule_index = idx[11:0];
    p.proto      = proto;
    p.src_addr   = sa;
    p.dst_addr   = da;
    p.src_len    = sl;
    p.dst_len    = dl;
    p.src_ports  = sp;
    p.dst_ports  = dp;
    p.prio       = prio;
    p.action     = act;
    return p;
  endfunction

  function automatic req_beat_t mk_pkt(logic [7:0] proto, logic [31:0] sa, logic [31:0] da,
                                       logic [15:0] sp, logic [15:0] dp);
    req_beat_t p;
    p = random_packet();
    p.proto           = proto;
    p.src_addr        = sa;
    p.dst_addr        = da;
    p.src_ports[15:0] = sp;
    p.dst_ports[15:0] = dp;
    return p;
  endfunction

  // Starts and ends at a falling edge; valid stays high until the next beat or gap.
  task automatic push_request(input req_beat_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.req_type       = b.kind;
    req_ch.bank           = b.bank;
    req_ch.rule_index     = b.rule_index;
    req_ch.proto          = b.proto;
    req_ch.src_addr       = b.src_addr;
    req_ch.dst_addr       = b.dst_addr;
    req_ch.src_prefix_len = b.src_len;
    req_ch.dst_prefix_len = b.dst_len;
    req_ch.src_ports      = b.src_ports;
    req_ch.dst_ports      = b.dst_ports;
    req_ch.rule_priority  = b.prio;
    req_ch.rule_action    = b.action;
    req_ch.valid          = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // Holds off the sender until every owed verdict is back and any rule write
  // accepted after the last classify has landed.
  task automatic settle();
    req_ch.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (WRITE_SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input fmrpc_pkg::cfg_reg_t r, input int unsigned v);
    cfg_ch.index = r;
    cfg_ch.data  = v[fmrpc_pkg::CFG_DATA_W-1:0];
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  initial begin : stimulus
    req_beat_t   b;
    int unsigned lim;
    logic        bank_pick;
    req_ch.valid          = 1'b0;
    req_ch.req_type       = fmrpc_pkg::REQ_CLASSIFY;
    req_ch.bank           = 1'b0;
    req_ch.rule_index     = '0;
    req_ch.proto          = '0;
    req_ch.src_addr       = '0;
    req_ch.dst_addr       = '0;
    req_ch.src_prefix_len = '0;
    req_ch.dst_prefix_len = '0;
    req_ch.src_ports      = '0;
    req_ch.dst_ports      = '0;
    req_ch.rule_priority  = '0;
    req_ch.rule_action    = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = fmrpc_pkg::CFG_ACTIVE_BANK;
    cfg_ch.data           = '0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // With no rules in use the default verdict comes back without any rule being read.
    push_request(mk_pkt(8'd17, 32'h0A01_0203, 32'h0101_0101, 16'd1234, 16'd53));

    // Bank 0: one rule per matching corner.
    push_request(mk_rule(1'b0, 0, 8'd17, 32'h0A00_0000, 6'd8, 32'hDEAD_BEEF, 6'd0,
                         32'h0, {16'd53, 16'd53}, 32'd100, 1'b1));
    push_request(mk_rule(1'b0, 1, 8'd6, 32'h0, 6'd0, 32'hC0A8_0100, 6'd24,
                         32'h0, {16'd2000, 16'd1000}, 32'd200, 1'b0));
    push_request(mk_rule(1'b0, 2, 8'd0, 32'hC0A8_0101, 6'd63, 32'h0, 6'd0,
                         32'h0, 32'h0, 32'h0, 1'b1));
    push_request(mk_rule(1'b0, 3, 8'd1, 32'h0, 6'd0, 32'h0, 6'd0,
                         {16'd400, 16'd500}, 32'h0, 32'd300, 1'b1));
    push_request(mk_rule(1'b0, 4, 8'd6, 32'h0, 6'd0, 32'hFFFF_FFFF, 6'd32,
                         {16'hFFFF, 16'd1}, {16'hFFFF, 16'hFFFF}, 32'hFFFF_FFFE, 1'b1));
    push_request(mk_rule(1'b0, 5, 8'd255, 32'h8000_0000, 6'd1, 32'h0102_0304, 6'd33,
                         32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0));
    push_request(mk_rule(1'b0, 6, 8'd47, 32'h0, 6'd0, 32'h0, 6'd0,
                         32'h0, 32'h0, 32'd7, 1'b0));
    push_request(mk_rule(1'b0, 7, 8'd0, 32'h0, 6'd0, 32'h0, 6'd0,
                         {16'hFFFF, 16'h8000}, 32'h0, 32'h55, 1'b1));
    settle();
    write_reg(fmrpc_pkg::CFG_RULES_IN_USE, 8);
    push_request(mk_pkt(8'd17, 32'h0A01_0203, 32'h0101_0101, 16'd1234, 16'd53));
    push_request(mk_pkt(8'd17, 32'h0A01_0203, 32'h0101_0101, 16'd1234, 16'd54));
    push_request(mk_pkt(8'd6, 32'h0B00_0001, 32'hC0A8_014D, 16'd1234, 16'd1000));
    push_request(mk_pkt(8'd6, 32'h0B00_0001, 32'hC0A8_014D, 16'd1234, 16'd2000));
    push_request(mk_pkt(8'd6, 32'h0B00_0001, 32'hC0A8_014D, 16'h8000, 16'd2001));
    push_request(mk_pkt(8'd99, 32'hC0A8_0101, 32'h0, 16'd5, 16'd5));
    push_request(mk_pkt(8'd99, 32'hC0A8_0100, 32'h0, 16'hFFFF, 16'd5));
    push_request(mk_pkt(8'd1, 32'h0, 32'h0, 16'd450, 16'd0));
    push_request(mk_pkt(8'd6, 32'h1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    push_request(mk_pkt(8'd255, 32'hFFFF_FFFF, 32'h0102_0304, 16'd0, 16'd0));
    push_request(mk_pkt(8'd47, 32'h1234_5678, 32'h9ABC_DEF0, 16'h0100, 16'd80));
    push_request(mk_pkt(8'd0, 32'h0, 32'h0, 16'd0, 16'd0));
    settle();
    write_reg(fmrpc_pkg::CFG_DEFAULT_ACTION, 1);
    push_request(mk_pkt(8'd1, 32'h0, 32'h0, 16'd450, 16'd0));

    // The low slots of bank 1 get narrow rules and then a catch-all, so a rule
    // count above the depth always stops before an unwritten slot.
    for (int unsigned i = 0; i < FILL_RULES; i++) begin
      b = random_rule(1'b1, i[11:0]);
      b.proto   = 8'($urandom_range(1, 255));
      b.src_len = 6'($urandom_range(16, 40));
      b.dst_len = 6'($urandom_range(16, 40));
      push_request(b);
    end
    push_request(mk_rule(1'b1, FILL_RULES, 8'd0, 32'h0, 6'd0, 32'h0, 6'd0,
                         32'h0, 32'h0, CATCH_ALL_PRIO, 1'b1));
    settle();
    write_reg(fmrpc_pkg::CFG_ACTIVE_BANK, 1);
    write_reg(fmrpc_pkg::CFG_RULES_IN_USE, 32'h1FFF);
    push_request(packet_for_slot(1'b1, FILL_RULES - 1));
    push_request(packet_for_slot(1'b1, FILL_RULES / 2));
    push_request(random_packet());
    push_request(random_packet());
    settle();
    write_reg(fmrpc_pkg::CFG_RULES_IN_USE, DEPTH);
    push_request(packet_for_slot(1'b1, FILL_RULES - 1));
    push_request(random_packet());

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 17; recv_stall_pct = 45; end
        1: begin send_idle_pct = 45; recv_stall_pct = 17; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      settle();
      bank_pick = (ph == 2) ? 1'($urandom_range(0, 1)) : ph[0];
      lim = sb.written_prefix(bank_pick);
      if (lim > SMALL_SCAN) lim = SMALL_SCAN;
      write_reg(fmrpc_pkg::CFG_ACTIVE_BANK, 32'(bank_pick));
      write_reg(fmrpc_pkg::CFG_DEFAULT_ACTION, $urandom_range(0, 1));
      write_reg(fmrpc_pkg::CFG_RULES_IN_USE, $urandom_range(lim / 2, lim));
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) settle();
        if ($urandom_range(0, 99) < 35) begin
          push_request(random_rule(1'($urandom_range(0, 1)),
                                   12'(($urandom_range(0, 99) < 70) ? $urandom_range(0, 31)
                                                                    : $urandom_range(0, 4095))));
        end else if (sb.scan_count() > 0 && $urandom_range(0, 99) < 70) begin
          push_request(packet_for_slot(sb.bank_sel, $urandom_range(0, sb.scan_count() - 1)));
        end else begin
          push_request(random_packet());
        end
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d rule writes and %0d classify beats, %0d of which hit a rule.",
             sb.writes, sb.classifies, sb.hits);
    $display("Bank 0 took the directed corner rules; bank 1 ended in a catch-all for oversized counts.");
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
